[hdl/iirdf_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf_pkg
// shared types and constants of the direct-form-I iir filter core
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf_pkg;

  // fixed field widths of the transaction payloads
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int IDX_W    = 4;
  localparam int ORDER_W  = 3;
  localparam int ACC_W    = 64;
  localparam int PROD_W   = COEF_W + SAMPLE_W;

  // parameter defaults
  localparam int MAX_ORDER_DEF      = 6;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // command field codes
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } iirdf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
    logic                       order_fault;
  } iirdf_out_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    OP_X0,   // b[0] * new sample
    OP_FB,   // a[k] * y history
    OP_FF    // b[k+1] * x history
  } iirdf_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic               coef_we;
    logic               capture;
    logic               acc_clr;
    logic               mul_en;
    iirdf_op_t          op_sel;
    logic               load_out;
    logic               hist_shift;
    logic               fault;
    logic [ORDER_W-1:0] order;
  } iirdf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } iirdf_stat_t;

endpackage

`default_nettype wire

[hdl/iirdf_ctrl.sv]
// ----------------------------------------------------------------------------
// iirdf_ctrl
// sequencer: steps the shared mac over the taps and hands off the result
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf_ctrl #(
  parameter int MAX_ORDER = iirdf_pkg::MAX_ORDER_DEF,
  parameter int KW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic                         cfg_wr_en,
  input  wire logic [iirdf_pkg::ORDER_W-1:0] cfg_wr_data,
  input  wire iirdf_pkg::iirdf_stat_t        stat_i,
  output iirdf_pkg::iirdf_cmd_t              cmd_o,
  output logic [KW-1:0]                     tap_idx_o
);
  import iirdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  iirdf_op_t          op_r, op_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic               fault_r, fault_nxt;
  logic [ORDER_W-1:0] order_r, order_nxt;

  logic in_fire;
  logic order_ok;
  logic last_tap;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign order_ok = (order_r != '0) && (int'(order_r) <= MAX_ORDER);
  assign last_tap = (int'(k_r) == int'(order_r) - 1);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    k_nxt     = k_r;
    fault_nxt = fault_r;
    order_nxt = cfg_wr_en ? cfg_wr_data : order_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_cmd == CMD_FILTER)) begin
          k_nxt     = '0;
          op_nxt    = OP_X0;
          fault_nxt = !order_ok;
          state_nxt = order_ok ? S_MAC : S_DONE;
        end
      end
      S_MAC: begin
        unique case (op_r)
          OP_X0: op_nxt = OP_FB;
          OP_FB: op_nxt = OP_FF;
          OP_FF: begin
            op_nxt = OP_FB;
            if (last_tap) begin
              state_nxt = S_DRAIN;
            end else begin
              k_nxt = k_r + KW'(1);
            end
          end
          default: op_nxt = OP_FB;
        endcase
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_X0;
      k_r     <= '0;
      fault_r <= 1'b0;
      order_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      k_r     <= k_nxt;
      fault_r <= fault_nxt;
      order_r <= order_nxt;
    end
  end

  always_comb begin
    cmd_o.coef_we    = in_fire && (in_cmd == CMD_LOAD);
    cmd_o.capture    = in_fire && (in_cmd == CMD_FILTER);
    cmd_o.acc_clr    = in_fire;
    cmd_o.mul_en     = (state_r == S_MAC);
    cmd_o.op_sel     = op_r;
    cmd_o.load_out   = (state_r == S_DONE) && stat_i.out_free;
    cmd_o.hist_shift = (state_r == S_DONE) && stat_i.out_free && !fault_r;
    cmd_o.fault      = fault_r;
    cmd_o.order      = order_r;
  end

  assign tap_idx_o = k_r;

endmodule

`default_nettype wire

[hdl/iirdf_datapath.sv]
// ----------------------------------------------------------------------------
// iirdf_datapath
// coefficient and history registers, shared mac, rounding and output register
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf_datapath #(
  parameter int MAX_ORDER      = iirdf_pkg::MAX_ORDER_DEF,
  parameter int COEF_FRAC_BITS = iirdf_pkg::COEF_FRAC_BITS_DEF,
  parameter int KW             = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire iirdf_pkg::iirdf_in_t   in_data,
  input  wire iirdf_pkg::iirdf_cmd_t  cmd_i,
  input  wire logic [KW-1:0]          tap_idx_i,
  output iirdf_pkg::iirdf_stat_t      stat_o,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output iirdf_pkg::iirdf_out_t       out_data
);
  import iirdf_pkg::*;

  localparam int FW = $clog2(MAX_ORDER + 1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  logic signed [COEF_W-1:0]   fb_r [MAX_ORDER];
  logic signed [COEF_W-1:0]   ff_r [MAX_ORDER+1];
  logic signed [SAMPLE_W-1:0] xh_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] yh_r [MAX_ORDER];

  logic signed [SAMPLE_W-1:0] x0_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  iirdf_out_t                 out_data_r;

  logic signed [COEF_W-1:0]   op_coef;
  logic signed [SAMPLE_W-1:0] op_smp;
  logic [FW-1:0]              ff_idx;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_clip;

  assign ff_idx = FW'(tap_idx_i) + FW'(1);

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.op_sel)
      OP_X0: begin
        op_coef = ff_r[0];
        op_smp  = x0_r;
      end
      OP_FB: begin
        op_coef = fb_r[tap_idx_i];
        op_smp  = yh_r[tap_idx_i];
      end
      OP_FF: begin
        op_coef = ff_r[ff_idx];
        op_smp  = xh_r[tap_idx_i];
      end
      default: begin
        op_coef = '0;
        op_smp  = '0;
      end
    endcase
  end

  // round half up, arithmetic shift, saturate
  always_comb begin
    rnd    = acc_r + RND_HALF;
    y_full = rnd >>> COEF_FRAC_BITS;
    y_clip = 1'b0;
    y_sat  = SAMPLE_W'(y_full);
    if (y_full > Y_MAX) begin
      y_sat  = SAMPLE_W'(Y_MAX);
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat  = SAMPLE_W'(Y_MIN);
      y_clip = 1'b1;
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        fb_r[i] <= '0;
      end
      for (int i = 0; i <= MAX_ORDER; i++) begin
        ff_r[i] <= '0;
      end
    end else if (cmd_i.coef_we) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        if (int'(in_data.coef_index) == i) begin
          fb_r[i] <= in_data.coef_value;
        end
      end
      for (int i = 0; i <= MAX_ORDER; i++) begin
        if (int'(in_data.coef_index) == i + MAX_ORDER) begin
          ff_r[i] <= in_data.coef_value;
        end
      end
    end
  end

  // histories, only the first order entries move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (cmd_i.hist_shift) begin
      xh_r[0] <= x0_r;
      yh_r[0] <= y_sat;
      for (int i = 1; i < MAX_ORDER; i++) begin
        if (i < int'(cmd_i.order)) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
      end
    end
  end

  // mac
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      x0_r <= in_data.sample_in;
    end
    if (cmd_i.mul_en) begin
      prod_r <= op_coef * op_smp;
    end
    if (cmd_i.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd_i.mul_en;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      if (cmd_i.fault) begin
        out_data_r.sample_out  <= '0;
        out_data_r.saturated   <= 1'b0;
        out_data_r.order_fault <= 1'b1;
      end else begin
        out_data_r.sample_out  <= y_sat;
        out_data_r.saturated   <= y_clip;
        out_data_r.order_fault <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

[hdl/iir_direct_form_filter_core.sv]
// ----------------------------------------------------------------------------
// iir_direct_form_filter_core
// direct-form-I iir filter, order 1 to MAX_ORDER, one shared mac
// ----------------------------------------------------------------------------
// a cmd=0 transaction filters one 16-bit signed sample and yields one result
// transaction; a cmd=1 transaction loads one q8.24 coefficient (slots
// 0..MAX_ORDER-1 are feedback a[k], the next MAX_ORDER+1 are feedforward b[k],
// higher slots are dropped) and yields nothing. the accumulator is 64 bits,
// the sum is rounded half up, shifted right by COEF_FRAC_BITS and saturated to
// 16 bits, and that value also enters the output history. with filter_order
// outside 1..MAX_ORDER a sample gives output 0 with order_fault set and leaves
// both histories alone. one multiplier serves all 2n+1 taps, one per cycle;
// a sample holds off the next transaction until its result is in the output
// register, a faulted sample skips the taps and a coefficient load leaves the
// core idle. the result sits in an output register, so the next transaction
// is accepted while it waits; the core stalls only when a new result is ready
// and the previous one has not been taken. filter_order is to be written
// through cfg_wr_en/cfg_wr_data only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_filter_core #(
  parameter int MAX_ORDER      = iirdf_pkg::MAX_ORDER_DEF,
  parameter int COEF_FRAC_BITS = iirdf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transactions
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire iirdf_pkg::iirdf_in_t          in_data,
  // result transactions
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output iirdf_pkg::iirdf_out_t              out_data,
  // filter_order register
  input  wire logic                          cfg_wr_en,
  input  wire logic [iirdf_pkg::ORDER_W-1:0] cfg_wr_data
);
  import iirdf_pkg::*;

  // width of the tap counter, indexes the history lines
  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  iirdf_cmd_t    cmd;
  iirdf_stat_t   stat;
  logic [KW-1:0] tap_idx;

  // sequencer: idle, mac over the taps, drain the product, hand off result
  iirdf_ctrl #(
    .MAX_ORDER (MAX_ORDER),
    .KW        (KW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_data.cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .tap_idx_o   (tap_idx)
  );

  // coefficient and history storage, multiplier, accumulator, output stage
  iirdf_datapath #(
    .MAX_ORDER      (MAX_ORDER),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .KW             (KW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .tap_idx_i (tap_idx),
    .stat_o    (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[test/iir_direct_form_filter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_direct_form_filter_core_tb
// self-checking bench for the direct-form-I iir filter core: a directed part
// covers order faults, rounding, saturation and dropped coefficient slots,
// then random phases cover edge and random orders with fresh coefficients while
// the sender bursts and the receiver stalls; every result is checked against
// a cycle-free model of the filter kept inside the bench
// ----------------------------------------------------------------------------

module iir_direct_form_filter_core_tb;
  import iirdf_pkg::*;

  localparam int MAX_ORD       = MAX_ORDER_DEF;
  localparam int FRAC_BITS     = COEF_FRAC_BITS_DEF;
  localparam int FF_SLOT0      = MAX_ORD;           // slot of b[0]
  localparam int NUM_SLOTS     = 2 * MAX_ORD + 1;   // a[0..5] then b[0..6]
  localparam int SLOT_LAST     = (1 << IDX_W) - 1;
  localparam int ORDER_LAST    = (1 << ORDER_W) - 1;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int SETTLE_CYCLES = 40;    // a full order-6 sample plus margin
  localparam int IDLE_LIMIT    = 4000;  // cycles without any handshake
  localparam int MAX_REPORTS   = 40;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 100;

  // q8.24 coefficient corner values
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh0100_0000;
  localparam logic signed [COEF_W-1:0] COEF_HALF = 32'sh0080_0000;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh8000_0000;

  // magnitude class of random coefficients
  typedef enum int {
    SCALE_GENTLE,  // about +-0.125
    SCALE_UNITY,   // about +-1.0
    SCALE_FULL     // whole q8.24 range
  } coef_scale_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  iirdf_in_t            in_data     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  iirdf_out_t           out_data;
  logic                 cfg_wr_en   = 1'b0;
  logic [ORDER_W-1:0]   cfg_wr_data = '0;

  always #2 clk = ~clk;

  iir_direct_form_filter_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // filter model: coefficients, histories and order mirrored from the core
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0]   fb_coef [MAX_ORD];
  logic signed [COEF_W-1:0]   ff_coef [MAX_ORD+1];
  logic signed [SAMPLE_W-1:0] x_hist  [MAX_ORD];
  logic signed [SAMPLE_W-1:0] y_hist  [MAX_ORD];
  logic [ORDER_W-1:0]         model_order;

  iirdf_out_t expected_out_q[$];
  int         error_count = 0;

  // apply one accepted transaction to the model, queue its result if any
  task automatic track_transaction(input iirdf_in_t item);
    logic signed [SAMPLE_W-1:0] x0;
    longint                     acc;
    longint                     y;
    iirdf_out_t                 res;
    int                         n;
    int                         k;
    n  = int'(model_order);
    x0 = item.sample_in;
    if (item.cmd == CMD_LOAD) begin
      // slots above the last b[k] are dropped
      if (item.coef_index < MAX_ORD) begin
        fb_coef[item.coef_index] = item.coef_value;
      end else if (item.coef_index < NUM_SLOTS) begin
        ff_coef[item.coef_index - MAX_ORD] = item.coef_value;
      end
      return;
    end
    res = '0;
    if (n < 1 || n > MAX_ORD) begin
      // bad order: zero output, fault flag, histories frozen
      res.order_fault = 1'b1;
    end else begin
      acc = longint'(ff_coef[0]) * longint'(x0);
      for (k = 0; k < n; k++) begin
        acc += longint'(fb_coef[k]) * longint'(y_hist[k]);
        acc += longint'(ff_coef[k+1]) * longint'(x_hist[k]);
      end
      // round half up, drop the fraction, clip to the sample range
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        res.saturated = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        res.saturated = 1'b1;
      end
      // only the first n history entries move
      for (k = n - 1; k > 0; k--) begin
        x_hist[k] = x_hist[k-1];
        y_hist[k] = y_hist[k-1];
      end
      x_hist[0]      = x0;
      y_hist[0]      = y[SAMPLE_W-1:0];
      res.sample_out = y[SAMPLE_W-1:0];
    end
    expected_out_q.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;

  // caller sits at a rising edge; returns at the edge of acceptance
  task automatic send_transaction(input iirdf_in_t item);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_transaction(item);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x);
    iirdf_in_t item;
    item.cmd        = CMD_FILTER;
    item.sample_in  = x;
    // unused fields carry noise
    item.coef_index = IDX_W'($urandom);
    item.coef_value = $urandom;
    send_transaction(item);
  endtask

  task automatic load_coef(input int slot, input logic signed [COEF_W-1:0] value);
    iirdf_in_t item;
    item.cmd        = CMD_LOAD;
    item.sample_in  = SAMPLE_W'($urandom);
    item.coef_index = IDX_W'(slot);
    item.coef_value = value;
    send_transaction(item);
  endtask

  // drop valid, let every result come back, then give a pending load time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] order);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_order = order;
    @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef(input coef_scale_t scale);
    logic signed [COEF_W-1:0] raw;
    raw = $urandom;
    case (scale)
      SCALE_GENTLE: return raw >>> 10;
      SCALE_UNITY:  return raw >>> 7;
      default:      return raw;
    endcase
  endfunction

  // mostly full-range samples, some small ones
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    return ($urandom_range(0, 3) == 0) ? raw >>> 7 : raw;
  endfunction

  // --------------------------------------------------------------------------
  // receiver: alternating ready and stall stretches of random length
  // --------------------------------------------------------------------------
  int ready_cnt = 0;

  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (ready_cnt == 0) begin
      out_ready <= ~out_ready;
      ready_cnt = out_ready ? $urandom_range(1, 24) : $urandom_range(1, 20);
    end else begin
      ready_cnt--;
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  iirdf_out_t exp_res;

  task automatic check_field(input string field, input longint exp_val,
                             input longint act_val);
    if (exp_val != act_val) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_out_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none pending, expected none, actual %0d/%0b/%0b",
                   $time, out_data.sample_out, out_data.saturated, out_data.order_fault);
      end else begin
        exp_res = expected_out_q.pop_front();
        check_field("sample_out", longint'(exp_res.sample_out),
                    longint'(out_data.sample_out));
        check_field("saturated", longint'(exp_res.saturated),
                    longint'(out_data.saturated));
        check_field("order_fault", longint'(exp_res.order_fault),
                    longint'(out_data.order_fault));
      end
    end
  end

  // watchdog: any handshake restarts the count
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("iir_direct_form_filter_core_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // order 0 after reset and order 7 both fault, loads still land
  task automatic test_order_fault();
    filter_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
    filter_sample(SAMPLE_MIN[SAMPLE_W-1:0]);
    load_coef(FF_SLOT0, COEF_ONE);
    filter_sample(16'sd1000);
    write_order(ORDER_W'(ORDER_LAST));
    filter_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
  endtask

  // unity gain passes samples, half gain shows round half up
  task automatic test_rounding_passthrough();
    write_order(ORDER_W'(1));
    filter_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
    filter_sample(SAMPLE_MIN[SAMPLE_W-1:0]);
    filter_sample(16'sd0);
    load_coef(FF_SLOT0, COEF_HALF);
    filter_sample(16'sd1);
    filter_sample(-16'sd1);
    filter_sample(16'sd3);
    filter_sample(-16'sd3);
  endtask

  // extreme b[0] against extreme samples clips both ways
  task automatic test_saturation();
    load_coef(FF_SLOT0, COEF_MAX);
    filter_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
    filter_sample(SAMPLE_MIN[SAMPLE_W-1:0]);
    load_coef(FF_SLOT0, COEF_MIN);
    filter_sample(SAMPLE_MIN[SAMPLE_W-1:0]);
    filter_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
  endtask

  // loads above the last feedforward slot must go nowhere
  task automatic test_dropped_slots();
    load_coef(FF_SLOT0, COEF_ONE);
    load_coef(NUM_SLOTS, COEF_MAX);
    load_coef(SLOT_LAST, COEF_MIN);
    filter_sample(16'sd12345);
  endtask

  // --------------------------------------------------------------------------
  // random phases: new order and coefficient set each, random traffic after
  // --------------------------------------------------------------------------
  task automatic test_random_filtering();
    int                 phase;
    int                 sent;
    int                 pick;
    int                 slot;
    coef_scale_t        scale;
    logic [ORDER_W-1:0] order;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      // first phases walk the order extremes, later ones favor valid orders
      case (phase)
        0:       order = ORDER_W'(1);
        1:       order = ORDER_W'(MAX_ORD);
        2:       order = '0;
        3:       order = ORDER_W'(ORDER_LAST);
        default: order = ($urandom_range(0, 7) == 0)
                         ? ORDER_W'($urandom_range(0, ORDER_LAST))
                         : ORDER_W'($urandom_range(1, MAX_ORD));
      endcase
      scale     = coef_scale_t'($urandom_range(SCALE_GENTLE, SCALE_FULL));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      write_order(order);
      for (slot = 0; slot < NUM_SLOTS; slot++) load_coef(slot, rand_coef(scale));
      sent = NUM_SLOTS;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          filter_sample(rand_sample());
          sent++;
        end else if (pick < 97) begin
          load_coef($urandom_range(0, NUM_SLOTS - 1), rand_coef(scale));
          sent++;
        end else begin
          // dropped slot, not counted
          load_coef($urandom_range(NUM_SLOTS, SLOT_LAST), $urandom);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < MAX_ORD; k++) begin
      fb_coef[k] = '0;
      x_hist[k]  = '0;
      y_hist[k]  = '0;
    end
    for (int k = 0; k <= MAX_ORD; k++) ff_coef[k] = '0;
    model_order = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_order_fault();
    test_rounding_passthrough();
    test_saturation();
    test_dropped_slots();
    test_random_filtering();

    // drain and let any stray result show up
    wait_idle();
    if (error_count == 0) begin
      $display("iir_direct_form_filter_core_tb OK");
    end else begin
      $display("iir_direct_form_filter_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/iirdf_pkg.sv
hdl/iirdf_ctrl.sv
hdl/iirdf_datapath.sv
hdl/iir_direct_form_filter_core.sv
test/iir_direct_form_filter_core_tb.sv
